FILE: src/assert_macros.svh
// Assertion macros used by the RTL of the LC-2K executor.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked property check, disabled while reset is asserted.
`define ASSERT_PROP(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Clocked check that a condition never holds outside reset.
`define ASSERT_NEVER(label, clk, rst_n, expr, msg) \
    `ASSERT_PROP(label, clk, rst_n, !(expr), msg)

`endif

FILE: src/lc2k_pkg.sv
// Types and constants of the LC-2K instruction executor.
`timescale 1ns / 1ps
`default_nettype none

package lc2k_pkg;

    // Request operation codes.
    localparam logic [1:0] OP_WRITE_MEM = 2'd0;
    localparam logic [1:0] OP_EXECUTE   = 2'd1;
    localparam logic [1:0] OP_READ_MEM  = 2'd2;
    localparam logic [1:0] OP_READ_REG  = 2'd3;

    // Instruction opcodes.
    localparam logic [2:0] OPC_ADD  = 3'd0;
    localparam logic [2:0] OPC_NOR  = 3'd1;
    localparam logic [2:0] OPC_LW   = 3'd2;
    localparam logic [2:0] OPC_SW   = 3'd3;
    localparam logic [2:0] OPC_BEQ  = 3'd4;
    localparam logic [2:0] OPC_JALR = 3'd5;
    localparam logic [2:0] OPC_HALT = 3'd6;
    localparam logic [2:0] OPC_NOOP = 3'd7;

    // Instruction word field positions.
    localparam int OPC_LSB  = 22;
    localparam int REGA_LSB = 19;
    localparam int REGB_LSB = 16;

    localparam int WORD_W  = 32;
    localparam int PC_W    = 16;
    localparam int RF_AW   = 3;
    localparam int RF_DEPTH = 8;

    typedef enum logic [1:0] {
        S_IDLE,
        S_DECODE,
        S_EXEC,
        S_LOAD
    } t_state;

    typedef enum logic [1:0] {
        FK_ZERO,
        FK_MEM,
        FK_REG
    } t_fast_kind;

    typedef struct packed {
        logic [WORD_W-1:0] read_data;
        logic [PC_W-1:0]   pc;
        logic              halted;
        logic [WORD_W-1:0] count;
    } t_result;

endpackage

`default_nettype wire

FILE: src/lc2k_instruction_executor_core.sv
// Top level of the LC-2K instruction executor: word memory, register file and sequencer.
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"

// Channel   Direction  Handshake                   Payload
// request   in         i_in_valid / o_in_ready     i_op, i_address, i_reg_index, i_write_data
// result    out        o_out_valid / i_out_ready   o_read_data, o_program_counter,
//                                                  o_halted, o_executed_count
//
// Memory writes, memory reads, register reads and execute requests after halt use the fast
// request stage and can be accepted back to back while the result queue has room.
// An execute request runs fetch, register read and execute, and lw adds a load step, as
// the word memory has a single read port and the register read follows the fetch.
// Reset clears pc, halt flag, counter and register-file valid bits; the word memory is not
// cleared. A two-entry result queue lets requests be accepted while results wait to be taken.
module lc2k_instruction_executor_core
    import lc2k_pkg::*;
#(
    parameter int ADDR_W = 16
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_rst_n,
    input  wire logic                     i_in_valid,
    output logic                          o_in_ready,
    input  wire logic [1:0]               i_op,
    input  wire logic [15:0]              i_address,
    input  wire logic [2:0]               i_reg_index,
    input  wire logic signed [31:0]       i_write_data,
    output logic                          o_out_valid,
    input  wire logic                     i_out_ready,
    output logic signed [31:0]            o_read_data,
    output logic [15:0]                   o_program_counter,
    output logic                          o_halted,
    output logic [31:0]                   o_executed_count
);

    localparam int MEM_WORDS = 1 << ADDR_W;

    // Storage: unified word memory and register file, both with registered reads.
    logic [WORD_W-1:0] r_mem [MEM_WORDS];
    logic [WORD_W-1:0] r_mem_rdata;
    logic [WORD_W-1:0] r_rf [RF_DEPTH];
    logic [RF_DEPTH-1:0] r_rf_vld;
    logic [WORD_W-1:0] r_rfa_data;
    logic [WORD_W-1:0] r_rfb_data;
    logic              r_rfa_vld;
    logic              r_rfb_vld;

    // Architectural state and sequencer.
    t_state            r_state, n_state;
    logic [ADDR_W-1:0] r_pc, n_pc;
    logic              r_halted, n_halted;
    logic [WORD_W-1:0] r_count, n_count;
    logic [WORD_W-1:0] r_instr;

    // Stage for the fast requests.
    logic              r_s1_vld;
    t_fast_kind        r_s1_kind;

    // Result queue and in-flight bookkeeping.
    t_result           r_fifo [2];
    logic              r_wr_ptr;
    logic              r_rd_ptr;
    logic [1:0]        r_fifo_cnt;
    logic [1:0]        r_pend;

    logic              accept;
    logic              pop;
    logic              exec_start;
    logic              push;
    t_result           push_res;
    logic [WORD_W-1:0] fast_data;

    logic              mem_we;
    logic [ADDR_W-1:0] mem_waddr;
    logic [ADDR_W-1:0] mem_raddr;
    logic [WORD_W-1:0] mem_wdata;

    logic [RF_AW-1:0]  rfa_addr;
    logic [RF_AW-1:0]  rfb_addr;
    logic              rf_we;
    logic [RF_AW-1:0]  rf_waddr;
    logic [WORD_W-1:0] rf_wdata;

    logic [2:0]        opc;
    logic [RF_AW-1:0]  ra_idx;
    logic [RF_AW-1:0]  rb_idx;
    logic [RF_AW-1:0]  rd_idx;
    logic [ADDR_W-1:0] off_lo;
    logic [WORD_W-1:0] ra_val;
    logic [WORD_W-1:0] rb_val;
    logic [ADDR_W-1:0] pc_plus1;
    logic [ADDR_W-1:0] data_addr;

    // Handshakes. New requests wait while an instruction is in flight and while the
    // result queue, counting results still in the pipeline, has no free slot.
    assign o_out_valid = (r_fifo_cnt != 2'd0);
    assign pop         = o_out_valid && i_out_ready;
    assign o_in_ready  = (r_state == S_IDLE) && ((r_pend < 2'd2) || pop);
    assign accept      = i_in_valid && o_in_ready;
    assign exec_start  = accept && (i_op == OP_EXECUTE) && !r_halted;

    // Instruction fields, taken from the word captured after the fetch.
    assign opc       = r_instr[OPC_LSB +: 3];
    assign ra_idx    = r_instr[REGA_LSB +: RF_AW];
    assign rb_idx    = r_instr[REGB_LSB +: RF_AW];
    assign rd_idx    = r_instr[RF_AW-1:0];
    assign off_lo    = r_instr[ADDR_W-1:0];
    assign ra_val    = r_rfa_vld ? r_rfa_data : '0;
    assign rb_val    = r_rfb_vld ? r_rfb_data : '0;
    assign pc_plus1  = r_pc + ADDR_W'(1);
    // Addresses wrap modulo the memory depth, so only the low bits of the sum matter.
    assign data_addr = ra_val[ADDR_W-1:0] + off_lo;

    // Register-file read addresses: port A takes the request's index when idle and regA during
    // decode; port B always takes regB from the fetched word.
    assign rfa_addr = (r_state == S_DECODE) ? r_mem_rdata[REGA_LSB +: RF_AW] : i_reg_index;
    assign rfb_addr = r_mem_rdata[REGB_LSB +: RF_AW];

    // Word memory port selection. Execution and new requests never share a cycle.
    always_comb begin
        mem_we    = 1'b0;
        mem_waddr = i_address[ADDR_W-1:0];
        mem_wdata = i_write_data;
        mem_raddr = i_address[ADDR_W-1:0];
        if (r_state == S_EXEC) begin
            mem_raddr = data_addr;
            mem_waddr = data_addr;
            mem_wdata = rb_val;
            mem_we    = (opc == OPC_SW);
        end else if (accept) begin
            mem_we = (i_op == OP_WRITE_MEM);
            if (i_op == OP_EXECUTE) begin
                mem_raddr = r_pc;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            r_mem[mem_waddr] <= mem_wdata;
        end
        r_mem_rdata <= r_mem[mem_raddr];
    end

    // Register file with two registered read ports and one write port.
    always_ff @(posedge i_clk) begin
        if (rf_we) begin
            r_rf[rf_waddr] <= rf_wdata;
        end
        r_rfa_data <= r_rf[rfa_addr];
        r_rfb_data <= r_rf[rfb_addr];
    end

    // Valid bits make never-written registers read as zero after reset.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rf_vld  <= '0;
            r_rfa_vld <= 1'b0;
            r_rfb_vld <= 1'b0;
        end else begin
            if (rf_we) begin
                r_rf_vld[rf_waddr] <= 1'b1;
            end
            r_rfa_vld <= r_rf_vld[rfa_addr];
            r_rfb_vld <= r_rf_vld[rfb_addr];
        end
    end

    // Sequencer state register and architectural state.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_pc     <= '0;
            r_halted <= 1'b0;
            r_count  <= '0;
        end else begin
            r_state  <= n_state;
            r_pc     <= n_pc;
            r_halted <= n_halted;
            r_count  <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_state == S_DECODE) begin
            r_instr <= r_mem_rdata;
        end
    end

    // Next state, architectural updates and register-file writes.
    always_comb begin
        n_state  = r_state;
        n_pc     = r_pc;
        n_halted = r_halted;
        n_count  = r_count;
        rf_we    = 1'b0;
        rf_waddr = rd_idx;
        rf_wdata = ra_val + rb_val;
        unique case (r_state)
            S_IDLE: begin
                if (exec_start) begin
                    n_state = S_DECODE;
                end
            end
            S_DECODE: begin
                n_state = S_EXEC;
            end
            S_EXEC: begin
                n_state = S_IDLE;
                n_pc    = pc_plus1;
                n_count = (r_count == '1) ? r_count : r_count + WORD_W'(1);
                unique case (opc)
                    OPC_ADD: begin
                        rf_we = 1'b1;
                    end
                    OPC_NOR: begin
                        rf_we    = 1'b1;
                        rf_wdata = ~(ra_val | rb_val);
                    end
                    OPC_LW: begin
                        n_state = S_LOAD;
                    end
                    OPC_SW: begin
                        n_pc = pc_plus1;
                    end
                    OPC_BEQ: begin
                        if (ra_val == rb_val) begin
                            n_pc = pc_plus1 + off_lo;
                        end
                    end
                    OPC_JALR: begin
                        rf_we    = 1'b1;
                        rf_waddr = rb_idx;
                        rf_wdata = WORD_W'(pc_plus1);
                        // regA is read after the link write, so equal indices fall through.
                        n_pc = (ra_idx == rb_idx) ? pc_plus1 : ra_val[ADDR_W-1:0];
                    end
                    OPC_HALT: begin
                        n_halted = 1'b1;
                    end
                    default: begin
                        n_pc = pc_plus1;
                    end
                endcase
            end
            S_LOAD: begin
                n_state  = S_IDLE;
                rf_we    = 1'b1;
                rf_waddr = rb_idx;
                rf_wdata = r_mem_rdata;
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // Fast request stage.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_vld <= 1'b0;
        end else begin
            r_s1_vld <= accept && !exec_start;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            case (i_op)
                OP_READ_MEM: r_s1_kind <= FK_MEM;
                OP_READ_REG: r_s1_kind <= FK_REG;
                default:     r_s1_kind <= FK_ZERO;
            endcase
        end
    end

    always_comb begin
        case (r_s1_kind)
            FK_MEM:  fast_data = r_mem_rdata;
            FK_REG:  fast_data = ra_val;
            default: fast_data = '0;
        endcase
    end

    // Results enter the queue from the fast stage or at the end of an instruction.
    assign push = r_s1_vld
               || ((r_state == S_EXEC) && (opc != OPC_LW))
               || (r_state == S_LOAD);

    always_comb begin
        push_res.read_data = r_s1_vld ? fast_data : '0;
        push_res.pc        = PC_W'(n_pc);
        push_res.halted    = n_halted;
        push_res.count     = n_count;
    end

    always_ff @(posedge i_clk) begin
        if (push) begin
            r_fifo[r_wr_ptr] <= push_res;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr   <= 1'b0;
            r_rd_ptr   <= 1'b0;
            r_fifo_cnt <= 2'd0;
            r_pend     <= 2'd0;
        end else begin
            if (push) begin
                r_wr_ptr <= !r_wr_ptr;
            end
            if (pop) begin
                r_rd_ptr <= !r_rd_ptr;
            end
            r_fifo_cnt <= r_fifo_cnt + 2'(push) - 2'(pop);
            r_pend     <= r_pend + 2'(accept) - 2'(pop);
        end
    end

    assign o_read_data       = r_fifo[r_rd_ptr].read_data;
    assign o_program_counter = r_fifo[r_rd_ptr].pc;
    assign o_halted          = r_fifo[r_rd_ptr].halted;
    assign o_executed_count  = r_fifo[r_rd_ptr].count;

    // Queued results never outnumber the requests still owed a result, which never exceed two.
    `ASSERT_PROP(a_pend_bound, i_clk, i_rst_n, (r_pend <= 2'd2) && (r_fifo_cnt <= r_pend), "pending count out of range")
    // An execute request before halt always starts the sequencer.
    `ASSERT_PROP(a_exec_start, i_clk, i_rst_n, exec_start |=> (r_state == S_DECODE), "execute did not start")
    // Halt is sticky until reset.
    `ASSERT_PROP(a_halt_sticky, i_clk, i_rst_n, r_halted |=> r_halted, "halt flag cleared")
    // The instruction counter never goes backward.
    `ASSERT_NEVER(a_count_mono, i_clk, i_rst_n, r_count < $past(r_count), "instruction count decreased")

endmodule

`default_nettype wire
